// ===== rtl/font5x7_char_rasterizer_unit_assert.svh =====
// assertion macros used by font5x7_char_rasterizer_unit.sv
`ifndef FONT5X7_CHAR_RASTERIZER_UNIT_ASSERT_SVH
`define FONT5X7_CHAR_RASTERIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define F5X7_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("f5x7 assertion failed");
`define F5X7_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("f5x7 assertion failed");
`define F5X7_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("f5x7 assertion failed");
`else
`define F5X7_ASSERT(lbl, prop)
`define F5X7_ASSERT_IMPL(lbl, ante, cons)
`define F5X7_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/f5x7_pkg.sv =====
package f5x7_pkg;

  localparam int CoordBits = 12;
  localparam int PixBits   = CoordBits - 1;
  localparam int ColorBits = 16;
  localparam int CodeBits  = 8;

  localparam int GlyphW   = 5;
  localparam int GlyphH   = 7;
  localparam int CellW    = 6;
  localparam int CellH    = 8;
  localparam int NumCells = CellW * CellH;
  localparam int CellBits = $clog2(NumCells);
  localparam int RowBits  = $clog2(CellH);
  localparam int ColBits  = CellBits - RowBits;

  localparam logic [CodeBits-1:0] FirstCode = 8'd32;
  localparam logic [CodeBits-1:0] LastCode  = 8'd127;
  localparam logic [CodeBits-1:0] SubstCode = 8'd63;

  localparam logic [CoordBits-1:0] MaxExtent   = CoordBits'(1 << (CoordBits - 1));
  localparam logic [CoordBits-1:0] ResetWidth  = CoordBits'(320);
  localparam logic [CoordBits-1:0] ResetHeight = CoordBits'(240);

  localparam int RegIdxBits = 2;
  localparam logic [RegIdxBits-1:0] RegScreenWidth  = 2'd0;
  localparam logic [RegIdxBits-1:0] RegScreenHeight = 2'd1;

  // one byte per glyph column, bit 0 is the top row
  typedef logic [0:GlyphW-1][7:0] glyph_t;

  typedef struct packed {
    logic [CoordBits-1:0] ox;
    logic [CoordBits-1:0] oy;
    glyph_t               glyph;
    logic [ColorBits-1:0] fg;
    logic [ColorBits-1:0] bg;
    logic                 fill;
  } item_t;

  typedef struct packed {
    logic [NumCells-1:0] on;
    logic [NumCells-1:0] emit;
  } cell_map_t;

  function automatic glyph_t glyph_lookup(input logic [CodeBits-1:0] code);
    logic [CodeBits-1:0] sel;
    logic [6:0]          idx;
    glyph_t              g;
    sel = (code < FirstCode || code > LastCode) ? SubstCode : code;
    idx = 7'(sel - FirstCode);
    case (idx)
      7'd0:  g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      7'd1:  g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
      7'd2:  g = {8'h00, 8'h07, 8'h00, 8'h07, 8'h00};
      7'd3:  g = {8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14};
      7'd4:  g = {8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12};
      7'd5:  g = {8'h23, 8'h13, 8'h08, 8'h64, 8'h62};
      7'd6:  g = {8'h36, 8'h49, 8'h55, 8'h22, 8'h50};
      7'd7:  g = {8'h00, 8'h05, 8'h03, 8'h00, 8'h00};
      7'd8:  g = {8'h00, 8'h1C, 8'h22, 8'h41, 8'h00};
      7'd9:  g = {8'h00, 8'h41, 8'h22, 8'h1C, 8'h00};
      7'd10: g = {8'h14, 8'h08, 8'h3E, 8'h08, 8'h14};
      7'd11: g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
      7'd12: g = {8'h00, 8'h50, 8'h30, 8'h00, 8'h00};
      7'd13: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      7'd14: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      7'd15: g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
      7'd16: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      7'd17: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      7'd18: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      7'd19: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      7'd20: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      7'd21: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      7'd22: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      7'd23: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      7'd24: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      7'd25: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      7'd26: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      7'd27: g = {8'h00, 8'h56, 8'h36, 8'h00, 8'h00};
      7'd28: g = {8'h08, 8'h14, 8'h22, 8'h41, 8'h00};
      7'd29: g = {8'h14, 8'h14, 8'h14, 8'h14, 8'h14};
      7'd30: g = {8'h00, 8'h41, 8'h22, 8'h14, 8'h08};
      7'd31: g = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
      7'd32: g = {8'h32, 8'h49, 8'h79, 8'h41, 8'h3E};
      7'd33: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      7'd34: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      7'd35: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      7'd36: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      7'd37: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      7'd38: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      7'd39: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      7'd40: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      7'd41: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      7'd42: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      7'd43: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      7'd44: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      7'd45: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      7'd46: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      7'd47: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      7'd48: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      7'd49: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      7'd50: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      7'd51: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      7'd52: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      7'd53: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      7'd54: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      7'd55: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
      7'd56: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      7'd57: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      7'd58: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      7'd59: g = {8'h00, 8'h7F, 8'h41, 8'h41, 8'h00};
      7'd60: g = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
      7'd61: g = {8'h00, 8'h41, 8'h41, 8'h7F, 8'h00};
      7'd62: g = {8'h04, 8'h02, 8'h01, 8'h02, 8'h04};
      7'd63: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
      7'd64: g = {8'h00, 8'h01, 8'h02, 8'h04, 8'h00};
      7'd65: g = {8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
      7'd66: g = {8'h7F, 8'h48, 8'h44, 8'h44, 8'h38};
      7'd67: g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h20};
      7'd68: g = {8'h38, 8'h44, 8'h44, 8'h48, 8'h7F};
      7'd69: g = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
      7'd70: g = {8'h08, 8'h7E, 8'h09, 8'h01, 8'h02};
      7'd71: g = {8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E};
      7'd72: g = {8'h7F, 8'h08, 8'h04, 8'h04, 8'h78};
      7'd73: g = {8'h00, 8'h44, 8'h7D, 8'h40, 8'h00};
      7'd74: g = {8'h20, 8'h40, 8'h44, 8'h3D, 8'h00};
      7'd75: g = {8'h7F, 8'h10, 8'h28, 8'h44, 8'h00};
      7'd76: g = {8'h00, 8'h41, 8'h7F, 8'h40, 8'h00};
      7'd77: g = {8'h7C, 8'h04, 8'h18, 8'h04, 8'h78};
      7'd78: g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h78};
      7'd79: g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
      7'd80: g = {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
      7'd81: g = {8'h08, 8'h14, 8'h14, 8'h18, 8'h7C};
      7'd82: g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h08};
      7'd83: g = {8'h48, 8'h54, 8'h54, 8'h54, 8'h20};
      7'd84: g = {8'h04, 8'h3F, 8'h44, 8'h40, 8'h20};
      7'd85: g = {8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C};
      7'd86: g = {8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C};
      7'd87: g = {8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C};
      7'd88: g = {8'h44, 8'h28, 8'h10, 8'h28, 8'h44};
      7'd89: g = {8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C};
      7'd90: g = {8'h44, 8'h64, 8'h54, 8'h4C, 8'h44};
      7'd91: g = {8'h00, 8'h08, 8'h36, 8'h41, 8'h00};
      7'd92: g = {8'h00, 8'h00, 8'h7F, 8'h00, 8'h00};
      7'd93: g = {8'h00, 8'h41, 8'h36, 8'h08, 8'h00};
      7'd94: g = {8'h08, 8'h04, 8'h08, 8'h10, 8'h08};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/f5x7_emit_map.sv =====
module f5x7_emit_map
  import f5x7_pkg::*;
(
  input  item_t                item_i,
  input  logic [CoordBits-1:0] wlim_i,
  input  logic [CoordBits-1:0] hlim_i,
  output cell_map_t            map_o
);

  logic [CoordBits:0]   px [CellW];
  logic [CoordBits:0]   py [CellH];
  logic [CellW-1:0]     x_ok;
  logic [CellH-1:0]     y_ok;
  logic [NumCells-1:0]  on;

  // a coordinate is on screen when non-negative and below the limit
  always_comb begin
    for (int c = 0; c < CellW; c++) begin
      px[c]   = {item_i.ox[CoordBits-1], item_i.ox} + (CoordBits+1)'(c);
      x_ok[c] = !px[c][CoordBits] && (px[c][CoordBits-1:0] < wlim_i);
    end
    for (int r = 0; r < CellH; r++) begin
      py[r]   = {item_i.oy[CoordBits-1], item_i.oy} + (CoordBits+1)'(r);
      y_ok[r] = !py[r][CoordBits] && (py[r][CoordBits-1:0] < hlim_i);
    end
  end

  for (genvar c = 0; c < CellW; c++) begin : g_col
    for (genvar r = 0; r < CellH; r++) begin : g_row
      if (c < GlyphW && r < GlyphH) begin : g_ink
        assign on[c*CellH+r] = item_i.glyph[c][r];
      end else begin : g_blank
        assign on[c*CellH+r] = 1'b0;
      end
      assign map_o.emit[c*CellH+r] = (on[c*CellH+r] | item_i.fill) & x_ok[c] & y_ok[r];
    end
  end

  assign map_o.on = on;

endmodule

// ===== rtl/font5x7_char_rasterizer_unit.sv =====
// channel   | dir | tdata (low bit up)                       | tuser / tlast
// s_axis    | in  | origin_x, origin_y, char_code, fg, bg    | tuser: fill_background
// m_axis    | out | pixel_x, pixel_y, pixel_color, 2'b0 pad  | tlast: last_write
// cfg       | in  | index 0 screen_width, 1 screen_height    | -
//
// the scan counter visits one cell of the 6x8 cell per cycle, and at most one pixel
// write leaves per cycle.
// the next character is taken in the cycle that visits the last cell.
// a stalled output register holds the scan; a cell with no write is still visited by the scan.
// reset empties the scan and output register and sets the screen to 320x240.
`include "font5x7_char_rasterizer_unit_assert.svh"

module font5x7_char_rasterizer_unit
  import f5x7_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // origin_x[11:0], origin_y[23:12], char_code[31:24], fg_color[47:32], bg_color[63:48]
  input  logic [63:0]           s_axis_tdata,
  // fill_background
  input  logic                  s_axis_tuser,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_x[10:0], pixel_y[21:11], pixel_color[37:22], zero[39:38]
  output logic [39:0]           m_axis_tdata,
  // last_write
  output logic                  m_axis_tlast,

  input  logic                  cfg_we_i,
  input  logic [RegIdxBits-1:0] cfg_idx_i,
  input  logic [CoordBits-1:0]  cfg_wdata_i
);

  logic [CoordBits-1:0] width_q, height_q;
  logic [CoordBits-1:0] wlim, hlim;

  item_t                item_q;
  item_t                item_d;
  logic                 busy_q;
  logic [CellBits-1:0]  cell_q;

  logic                 out_valid_q;
  logic [PixBits-1:0]   out_x_q, out_y_q;
  logic [ColorBits-1:0] out_color_q;
  logic                 out_last_q;

  cell_map_t            cmap;
  logic [NumCells-1:0]  rest;
  logic                 adv, scan_end, in_acc, cur_emit, later;
  logic [ColBits-1:0]   col;
  logic [RowBits-1:0]   row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegScreenWidth:  width_q  <= cfg_wdata_i;
        RegScreenHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign wlim = (width_q > MaxExtent) ? MaxExtent : width_q;
  assign hlim = (height_q > MaxExtent) ? MaxExtent : height_q;

  f5x7_emit_map u_map (
    .item_i (item_q),
    .wlim_i (wlim),
    .hlim_i (hlim),
    .map_o  (cmap)
  );

  assign col      = cell_q[CellBits-1:RowBits];
  assign row      = cell_q[RowBits-1:0];
  assign adv      = busy_q && (!out_valid_q || m_axis_tready);
  assign scan_end = (cell_q == CellBits'(NumCells - 1));
  assign s_axis_tready = !busy_q || (adv && scan_end);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cur_emit = cmap.emit[cell_q];
  assign rest     = cmap.emit >> cell_q;
  // no further write in a later cell means this one closes the character
  assign later    = |rest[NumCells-1:1];

  always_comb begin
    item_d.ox    = s_axis_tdata[11:0];
    item_d.oy    = s_axis_tdata[23:12];
    item_d.glyph = glyph_lookup(s_axis_tdata[31:24]);
    item_d.fg    = s_axis_tdata[47:32];
    item_d.bg    = s_axis_tdata[63:48];
    item_d.fill  = s_axis_tuser;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cell_q <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      cell_q <= '0;
    end else if (adv) begin
      busy_q <= !scan_end;
      cell_q <= scan_end ? '0 : cell_q + CellBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cur_emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cur_emit) begin
      out_x_q     <= item_q.ox[PixBits-1:0] + PixBits'(col);
      out_y_q     <= item_q.oy[PixBits-1:0] + PixBits'(row);
      out_color_q <= cmap.on[cell_q] ? item_q.fg : item_q.bg;
      out_last_q  <= !later;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_color_q, out_y_q, out_x_q};
  assign m_axis_tlast  = out_last_q;

  // a write waiting with no scan in progress has to be the closing one
  `F5X7_ASSERT_IMPL(a_idle_out_last, out_valid_q && !busy_q, out_last_q)
  // a write that is not the last leaves more of the character to scan
  `F5X7_ASSERT_IMPL(a_not_last_busy, m_axis_tvalid && m_axis_tready && !m_axis_tlast, busy_q)
  // every accepted character starts its scan at the first cell
  `F5X7_ASSERT_NEXT(a_accept_start, in_acc, busy_q && cell_q == '0)

endmodule

// ===== tb/sv/glyph_write_checker.sv =====
module glyph_write_checker
  import f5x7_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  char_valid_i,
  input  logic                  char_ready_i,
  // origin_x[11:0], origin_y[23:12], char_code[31:24], fg_color[47:32], bg_color[63:48]
  input  logic [63:0]           char_data_i,
  // fill_background
  input  logic                  char_fill_i,

  input  logic                  pix_valid_i,
  input  logic                  pix_ready_i,
  // pixel_x[10:0], pixel_y[21:11], pixel_color[37:22], zero[39:38]
  input  logic [39:0]           pix_data_i,
  // last_write
  input  logic                  pix_last_i,

  input  logic                  cfg_we_i,
  input  logic [RegIdxBits-1:0] cfg_idx_i,
  input  logic [CoordBits-1:0]  cfg_wdata_i,

  output int unsigned           mismatches_o,
  output int unsigned           outstanding_o,
  output int unsigned           writes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] FontFirst = 8'd32;
  localparam logic [7:0] FontLast  = 8'd127;
  localparam logic [7:0] FontSubst = 8'h3F;
  localparam int         CellCols  = 6;
  localparam int         CellRows  = 8;
  localparam int         GlyphCols = 5;
  localparam int         GlyphRows = 7;
  localparam int         ScreenCap = 2048;
  localparam int         MaxReports = 30;

  // one entry per code from 32 up, first glyph column in the top byte, bit 0 = top row
  localparam logic [0:95][39:0] FontRom = {
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
    40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
    40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h08_04_08_10_08, 40'h00_00_00_00_00
  };

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
    logic [15:0] color;
    logic        last;
  } pix_write_t;

  pix_write_t           pending_writes[$];
  logic [CoordBits-1:0] scr_w;
  logic [CoordBits-1:0] scr_h;
  int unsigned          mismatch_cnt;
  int unsigned          write_cnt;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports)
      $display("checker: %s mismatch at %0t: got 0x%0h want 0x%0h", what, $time, got, want);
  endtask

  // expected pixel writes for one character, column by column, top to bottom
  task automatic rasterize_char(input logic [63:0] data, input logic fill);
    int          ox;
    int          oy;
    int          wlim;
    int          hlim;
    int          px;
    int          py;
    logic [7:0]  code;
    logic [39:0] cols;
    logic [7:0]  bits;
    logic        lit;
    logic        have_prev;
    pix_write_t  prev;
    pix_write_t  w;
    ox = int'($signed(data[11:0]));
    oy = int'($signed(data[23:12]));
    code = data[31:24];
    wlim = (scr_w > ScreenCap) ? ScreenCap : int'(scr_w);
    hlim = (scr_h > ScreenCap) ? ScreenCap : int'(scr_h);
    if (code < FontFirst || code > FontLast) code = FontSubst;
    cols = FontRom[7'(code - FontFirst)];
    have_prev = 1'b0;
    prev = '0;
    for (int cx = 0; cx < CellCols; cx++) begin
      bits = (cx < GlyphCols) ? cols[39 - 8 * cx -: 8] : 8'h00;
      for (int cy = 0; cy < CellRows; cy++) begin
        lit = (cy < GlyphRows) ? bits[cy] : 1'b0;
        px = ox + cx;
        py = oy + cy;
        if ((lit || fill) && px >= 0 && py >= 0 && px < wlim && py < hlim) begin
          w.x = px[10:0];
          w.y = py[10:0];
          w.color = lit ? data[47:32] : data[63:48];
          w.last = 1'b0;
          if (have_prev) pending_writes.push_back(prev);
          prev = w;
          have_prev = 1'b1;
        end
      end
    end
    if (have_prev) begin
      prev.last = 1'b1;
      pending_writes.push_back(prev);
    end
  endtask

  task automatic check_write();
    pix_write_t want;
    write_cnt++;
    if (pending_writes.size() == 0) begin
      report_mismatch("unexpected pixel write", pix_data_i[31:0], 0);
      return;
    end
    want = pending_writes.pop_front();
    if (pix_data_i[10:0] != want.x)
      report_mismatch("pixel_x", 32'(pix_data_i[10:0]), 32'(want.x));
    if (pix_data_i[21:11] != want.y)
      report_mismatch("pixel_y", 32'(pix_data_i[21:11]), 32'(want.y));
    if (pix_data_i[37:22] != want.color)
      report_mismatch("pixel_color", 32'(pix_data_i[37:22]), 32'(want.color));
    if (pix_data_i[39:38] != 2'b00) report_mismatch("tdata pad", 32'(pix_data_i[39:38]), 0);
    if (pix_last_i != want.last)
      report_mismatch("last_write", 32'(pix_last_i), 32'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w = 12'd320;
      scr_h = 12'd240;
      pending_writes.delete();
      mismatch_cnt = 0;
      write_cnt = 0;
      mismatches_o <= 0;
      outstanding_o <= 0;
      writes_o <= 0;
    end else begin
      if (char_valid_i && char_ready_i) rasterize_char(char_data_i, char_fill_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == RegScreenWidth) scr_w = cfg_wdata_i;
        else if (cfg_idx_i == RegScreenHeight) scr_h = cfg_wdata_i;
      end
      if (pix_valid_i && pix_ready_i) check_write();
      mismatches_o <= mismatch_cnt;
      outstanding_o <= pending_writes.size();
      writes_o <= write_cnt;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import f5x7_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned SettlePad  = 100;
  localparam int unsigned LongHold   = 400;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // origin_x[11:0], origin_y[23:12], char_code[31:24], fg_color[47:32], bg_color[63:48]
  logic [63:0]           s_axis_tdata  = '0;
  // fill_background
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // pixel_x[10:0], pixel_y[21:11], pixel_color[37:22], zero[39:38]
  logic [39:0]           m_axis_tdata;
  // last_write
  logic                  m_axis_tlast;
  logic                  cfg_we        = 1'b0;
  logic [RegIdxBits-1:0] cfg_idx       = '0;
  logic [CoordBits-1:0]  cfg_wdata     = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned writes;
  int unsigned chars_sent = 0;
  int unsigned settings   = 1;
  int unsigned cycles     = 0;
  bit          quiet_tx   = 1'b0;
  bit          quiet_rx   = 1'b0;
  bit          hold_req   = 1'b0;

  font5x7_char_rasterizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  glyph_write_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_valid_i  (s_axis_tvalid),
    .char_ready_i  (s_axis_tready),
    .char_data_i   (s_axis_tdata),
    .char_fill_i   (s_axis_tuser),
    .pix_valid_i   (m_axis_tvalid),
    .pix_ready_i   (m_axis_tready),
    .pix_data_i    (m_axis_tdata),
    .pix_last_i    (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .writes_o      (writes)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // origin mostly around the visible area, sometimes anywhere in the 12-bit range
  function automatic int pick_origin(input int lim);
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(0, lim + 8)) - 7;
    return int'($urandom_range(0, 4095));
  endfunction

  task automatic send_char(input int ox, input int oy, input int code,
                           input logic [15:0] fg, input logic [15:0] bg, input logic fill);
    int unsigned gap;
    gap = quiet_tx ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bg, fg, 8'(code), 12'(oy), 12'(ox)};
    s_axis_tuser  <= fill;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
  endtask

  // wait for every expected write, then let a trailing scan finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettlePad) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxBits-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= 12'(val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input int w, input int h, input int n, input bit quiet);
    int lim_x;
    int lim_y;
    int code;
    settle();
    write_reg(RegScreenWidth, w);
    write_reg(RegScreenHeight, h);
    settings++;
    quiet_tx = quiet;
    quiet_rx = quiet;
    lim_x = (w > 2048) ? 2048 : w;
    lim_y = (h > 2048) ? 2048 : h;
    repeat (n) begin
      code = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(32, 127);
      send_char(pick_origin(lim_x), pick_origin(lim_y), code, 16'($urandom), 16'($urandom),
                1'($urandom_range(0, 1)));
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  initial begin : output_side
    int unsigned run;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        run = LongHold;
      end else if (quiet_rx) begin
        m_axis_tready <= 1'b1;
        run = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        run = pick_gap() + 1;
      end else begin
        m_axis_tready <= 1'b1;
        run = $urandom_range(1, 12);
      end
      repeat (run) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default 320x240 screen
    send_char(10, 20, "A", 16'hF800, 16'h001F, 1'b0);
    send_char(10, 20, "A", 16'hF800, 16'h001F, 1'b1);
    send_char(0, 0, 0, 16'hFFFF, 16'h0000, 1'b1);
    send_char(30, 30, 31, 16'h0000, 16'hFFFF, 1'b0);
    send_char(40, 30, 128, 16'h1234, 16'hABCD, 1'b1);
    send_char(50, 30, 255, 16'hFFFF, 16'hFFFF, 1'b0);
    // blank glyphs: nothing drawn unless the background is filled
    send_char(60, 30, " ", 16'h07E0, 16'hF81F, 1'b0);
    send_char(60, 40, " ", 16'h07E0, 16'hF81F, 1'b1);
    send_char(70, 40, 127, 16'hFFFF, 16'h0000, 1'b0);
    send_char(70, 50, 127, 16'hAAAA, 16'h5555, 1'b1);
    send_char(80, 50, "~", 16'h5555, 16'hAAAA, 1'b1);
    // clipping at the screen borders and at the coordinate extremes
    send_char(-2048, -2048, "#", 16'hFFFF, 16'h0000, 1'b1);
    send_char(2047, 2047, "#", 16'hFFFF, 16'h0000, 1'b1);
    send_char(-3, -4, "M", 16'h0F0F, 16'hF0F0, 1'b1);
    send_char(317, 236, "W", 16'h00FF, 16'hFF00, 1'b1);
    send_char(-6, 100, "@", 16'h1111, 16'h2222, 1'b1);
    send_char(320, 100, "@", 16'h3333, 16'h4444, 1'b1);
    send_char(-5, -7, "$", 16'h8001, 16'h7FFE, 1'b1);
    send_char(314, 232, "B", 16'hC3C3, 16'h3C3C, 1'b1);
    send_char(100, 100, "g", 16'h0001, 16'h8000, 1'b0);
    settle();

    // output held off while characters keep coming
    quiet_tx = 1'b1;
    hold_req = 1'b1;
    repeat (8)
      send_char($urandom_range(0, 300), $urandom_range(0, 220), $urandom_range(33, 126),
                16'($urandom), 16'($urandom), 1'b1);
    quiet_tx = 1'b0;

    run_phase(1, 1, 20, 1'b0);
    run_phase(2048, 2048, 35, 1'b0);
    run_phase(0, 240, 10, 1'b0);
    run_phase(4095, 4095, 30, 1'b0);
    run_phase(320, 0, 8, 1'b0);
    run_phase(40, 30, 35, 1'b1);
    run_phase($urandom_range(1, 2048), $urandom_range(1, 2048), 35, 1'b0);
    run_phase(320, 240, 30, 1'b0);
    settle();

    $display("summary: %0d characters under %0d screen settings, %0d pixel writes checked",
             chars_sent, settings, writes);
    $display("summary: out-of-range codes, blank glyphs, clipped cells, long output hold-off");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
